/* hdl/plt_pkg.sv */
// Peer lease table shared package: sizes, command and topic state codes,
// controller state type and controller/datapath handshake structs.
// No dependencies.
package plt_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int CMD_W = 4;
   localparam int GEN_W = 32;
   localparam int ID_W = 32;
   localparam int IDX_W = 8;
   localparam int TIME_W = 32;
   localparam int COUNT_W = 16;
   localparam int TOPIC_W = 2;

   localparam logic [CMD_W-1:0] CMD_REBUILD   = 4'd0;
   localparam logic [CMD_W-1:0] CMD_READY     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_STOP      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_ADD       = 4'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_ACQUIRE   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 4'd6;
   localparam logic [CMD_W-1:0] CMD_RELEASE   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_COLLECT   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_TICK      = 4'd9;

   localparam logic [TOPIC_W-1:0] TOPIC_EMPTY    = 2'd0;
   localparam logic [TOPIC_W-1:0] TOPIC_CLEARING = 2'd1;
   localparam logic [TOPIC_W-1:0] TOPIC_READY    = 2'd2;
   localparam logic [TOPIC_W-1:0] TOPIC_STOPPING = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_done;
      logic out_free;
   } dp_status_type;

endpackage

/* hdl/plt_req_if.sv */
// Request channel interface: valid/ready handshake plus command payload.
// Depends on plt_pkg.
interface plt_req_if;
   import plt_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [GEN_W-1:0]   generation_in;
   logic [ID_W-1:0]    peer_id;
   logic [IDX_W-1:0]   slot_index;

   modport source (output valid, command, generation_in, peer_id, slot_index, input ready);
   modport sink (input valid, command, generation_in, peer_id, slot_index, output ready);
endinterface

/* hdl/plt_rsp_if.sv */
// Response channel interface: valid/ready handshake plus result payload.
// Depends on plt_pkg.
interface plt_rsp_if;
   import plt_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic [IDX_W-1:0]   granted_slot;
   logic [ID_W-1:0]    stale_mask;
   logic [GEN_W-1:0]   generation_out;
   logic [TOPIC_W-1:0] topic_state;
   logic [COUNT_W-1:0] peer_total;

   modport source (output valid, accepted, granted_slot, stale_mask, generation_out,
                   topic_state, peer_total, input ready);
   modport sink (input valid, accepted, granted_slot, stale_mask, generation_out,
                 topic_state, peer_total, output ready);
endinterface

/* hdl/peer_lease_table_top.sv */
// Peer lease table top level: ties controller and datapath to the channels.
// Depends on plt_pkg, plt_req_if, plt_rsp_if, plt_ctrl and plt_dp.
//
//   channel   direction  handshake                    payload
//   req_bus   in         valid/ready                  command, generation_in, peer_id, slot_index
//   rsp_bus   out        valid/ready                  accepted, granted_slot, stale_mask, ...
//   csr_*     in         csr_write_enable, no ready   stale_timeout (32 bit)
//
// One transaction at a time. Commands without a scan go from accept to the finish state,
// where the result register loads once the output register is free, and then back to idle.
// Acquire (nonzero id) and collect (nonzero timeout) first pass through a scan state,
// which reads one slot per cycle, up to SLOT_COUNT slots.
// The next request is taken while a result still waits in the output register.
// Synchronous reset clears all slots at once; no clearing pass.
module peer_lease_table_top (
   input  logic                       clock,
   input  logic                       reset,
   plt_req_if.sink                    req_bus,
   plt_rsp_if.source                  rsp_bus,
   input  logic                       csr_write_enable,
   input  logic [plt_pkg::TIME_W-1:0] csr_write_data
);
   import plt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   plt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   plt_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_command        (req_bus.command),
      .req_generation_in  (req_bus.generation_in),
      .req_peer_id        (req_bus.peer_id),
      .req_slot_index     (req_bus.slot_index),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_accepted       (rsp_bus.accepted),
      .rsp_granted_slot   (rsp_bus.granted_slot),
      .rsp_stale_mask     (rsp_bus.stale_mask),
      .rsp_generation_out (rsp_bus.generation_out),
      .rsp_topic_state    (rsp_bus.topic_state),
      .rsp_peer_total     (rsp_bus.peer_total)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while a transaction is in flight");

   a_grant_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.granted_slot != '0) |-> rsp_bus.accepted)
      else $error("nonzero granted slot without acceptance");

   a_empty_means_gen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.topic_state == TOPIC_EMPTY) |-> rsp_bus.generation_out == '0)
      else $error("empty topic reported with a nonzero generation");
`endif
endmodule

/* hdl/plt_ctrl.sv */
// Peer lease table controller: accept, slot scan and result hand-off sequencing.
// Depends on plt_pkg.
module plt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plt_pkg::dp_status_type status,
   output plt_pkg::dp_cmd_type   cmd
);
   import plt_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = status.scan_needed ? CS_SCAN : CS_FINISH;
            end
         end
         CS_SCAN: begin
            if (status.scan_done) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: begin
            if (status.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         CS_SCAN: begin
            cmd.step = 1'b1;
         end
         CS_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end
endmodule

/* hdl/plt_dp.sv */
// Peer lease table datapath: topic registers, slot arrays, scan unit and result register.
// Depends on plt_pkg.
module plt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  plt_pkg::dp_cmd_type           cmd,
   output plt_pkg::dp_status_type        status,
   input  logic                          csr_write_enable,
   input  logic [plt_pkg::TIME_W-1:0]    csr_write_data,
   input  logic [plt_pkg::CMD_W-1:0]     req_command,
   input  logic [plt_pkg::GEN_W-1:0]     req_generation_in,
   input  logic [plt_pkg::ID_W-1:0]      req_peer_id,
   input  logic [plt_pkg::IDX_W-1:0]     req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [plt_pkg::IDX_W-1:0]     rsp_granted_slot,
   output logic [plt_pkg::ID_W-1:0]      rsp_stale_mask,
   output logic [plt_pkg::GEN_W-1:0]     rsp_generation_out,
   output logic [plt_pkg::TOPIC_W-1:0]   rsp_topic_state,
   output logic [plt_pkg::COUNT_W-1:0]   rsp_peer_total
);
   import plt_pkg::*;

   logic [TIME_W-1:0]   timeout_ff;
   logic [GEN_W-1:0]    gen_ff, gen_in;
   logic [TOPIC_W-1:0]  topic_ff, topic_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [ID_W-1:0]     owner_ff [SLOT_COUNT];
   logic [TIME_W-1:0]   beat_ff [SLOT_COUNT];

   logic [CMD_W-1:0]    op_ff;
   logic [GEN_W-1:0]    gen_arg_ff;
   logic [ID_W-1:0]     id_arg_ff;
   logic [IDX_W-1:0]    idx_arg_ff;

   logic [SLOT_W-1:0]   scan_ff;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    granted_ff, granted_in;
   logic [ID_W-1:0]     mask_ff, mask_in;

   logic                rsp_valid_ff;
   logic                rsp_acc_ff, acc_in;
   logic [IDX_W-1:0]    rsp_granted_ff;
   logic [ID_W-1:0]     rsp_mask_ff;
   logic [GEN_W-1:0]    rsp_gen_ff;
   logic [TOPIC_W-1:0]  rsp_topic_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                rd_busy;
   logic [ID_W-1:0]     rd_owner;
   logic [TIME_W-1:0]   rd_beat;
   logic [TIME_W-1:0]   age;
   logic                hit;
   logic                gen_ok;
   logic                idx_ok;
   logic [SLOT_W-1:0]   idx_slot;
   logic                own_we, beat_we;
   logic [SLOT_W-1:0]   wr_addr;

   assign rd_busy  = busy_ff[scan_ff];
   assign rd_owner = owner_ff[scan_ff];
   assign rd_beat  = beat_ff[scan_ff];
   assign age      = time_ff - rd_beat;
   assign hit      = (op_ff == CMD_ACQUIRE) && !rd_busy;
   assign gen_ok   = (gen_arg_ff != '0) && (gen_arg_ff == gen_ff);
   assign idx_ok   = {1'b0, idx_arg_ff} < (IDX_W+1)'(SLOT_COUNT);
   assign idx_slot = idx_arg_ff[SLOT_W-1:0];

   assign status.scan_needed = ((req_command == CMD_ACQUIRE) && (req_peer_id != '0)) ||
                               ((req_command == CMD_COLLECT) && (timeout_ff != '0));
   assign status.scan_done   = hit || (scan_ff == SLOT_W'(SLOT_COUNT - 1));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      gen_in     = gen_ff;
      topic_in   = topic_ff;
      count_in   = count_ff;
      time_in    = time_ff;
      busy_in    = busy_ff;
      found_in   = found_ff;
      granted_in = granted_ff;
      mask_in    = mask_ff;
      acc_in     = 1'b0;
      own_we     = 1'b0;
      beat_we    = 1'b0;
      wr_addr    = scan_ff;
      if (cmd.step) begin
         if (op_ff == CMD_ACQUIRE) begin
            if (!rd_busy) begin
               busy_in[scan_ff] = 1'b1;
               own_we     = 1'b1;
               beat_we    = 1'b1;
               found_in   = 1'b1;
               granted_in = IDX_W'(scan_ff);
            end
         end else if (rd_busy && (age >= timeout_ff)) begin
            mask_in = mask_ff | rd_owner;
            busy_in[scan_ff] = 1'b0;
         end
      end
      if (cmd.finish) begin
         case (op_ff)
            CMD_REBUILD: begin
               topic_in = TOPIC_CLEARING;
               count_in = '0;
               busy_in  = '0;
               gen_in   = gen_ff + 1'b1;
            end
            CMD_READY: topic_in = TOPIC_READY;
            CMD_STOP:  topic_in = TOPIC_STOPPING;
            CMD_ADD: begin
               if (gen_ok && (topic_ff == TOPIC_READY)) begin
                  acc_in = 1'b1;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            CMD_REMOVE: begin
               if (gen_ok && (count_ff != '0)) begin
                  acc_in   = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            CMD_ACQUIRE: acc_in = found_ff;
            CMD_HEARTBEAT: begin
               if (idx_ok) begin
                  beat_we = 1'b1;
                  wr_addr = idx_slot;
               end
            end
            CMD_RELEASE: begin
               if (idx_ok) begin
                  busy_in[idx_slot] = 1'b0;
               end
            end
            CMD_TICK: time_in = time_ff + 1'b1;
            default: acc_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= '0;
         gen_ff       <= '0;
         topic_ff     <= TOPIC_EMPTY;
         count_ff     <= '0;
         time_ff      <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         gen_ff   <= gen_in;
         topic_ff <= topic_in;
         count_ff <= count_in;
         time_ff  <= time_in;
         busy_ff  <= busy_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_command;
         gen_arg_ff <= req_generation_in;
         id_arg_ff  <= req_peer_id;
         idx_arg_ff <= req_slot_index;
         scan_ff    <= '0;
         found_ff   <= 1'b0;
         granted_ff <= '0;
         mask_ff    <= '0;
      end else begin
         if (cmd.step) begin
            scan_ff <= scan_ff + 1'b1;
         end
         found_ff   <= found_in;
         granted_ff <= granted_in;
         mask_ff    <= mask_in;
      end
      if (own_we) begin
         owner_ff[wr_addr] <= id_arg_ff;
      end
      if (beat_we) begin
         beat_ff[wr_addr] <= time_ff;
      end
      if (cmd.finish) begin
         rsp_acc_ff     <= acc_in;
         rsp_granted_ff <= granted_ff;
         rsp_mask_ff    <= mask_ff;
         rsp_gen_ff     <= gen_in;
         rsp_topic_ff   <= topic_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_granted_slot   = rsp_granted_ff;
   assign rsp_stale_mask     = rsp_mask_ff;
   assign rsp_generation_out = rsp_gen_ff;
   assign rsp_topic_state    = rsp_topic_ff;
   assign rsp_peer_total     = rsp_count_ff;
endmodule
